// File: rtl/core/nar_pkg.sv
package nar_pkg;

	localparam int MAX_HELD    = 16;
	localparam int MAX_OCTAVES = 4;

	localparam int CNT_W     = $clog2(MAX_HELD + 1);
	localparam int IDX_W     = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
	localparam int OCT_W     = $clog2(MAX_OCTAVES + 1);
	localparam int TOT_W     = $clog2(MAX_HELD * MAX_OCTAVES + 1);
	localparam int PITCH_W   = 16;
	localparam int VEL_W     = 7;
	localparam int POS_W     = 48;
	localparam int SPL_W     = 20;
	localparam int LEN_W     = SPL_W + 5;
	localparam int CFG_W     = 20;
	localparam int CFG_IDX_W = 3;
	localparam int PROD_W    = LEN_W + 13;
	localparam int SUM_W     = PITCH_W + 2;

	localparam int OCT_STEP  = 3072;
	localparam logic [31:0] LCG_A   = 32'd1664525;
	localparam logic [31:0] LCG_C   = 32'd1013904223;
	localparam logic [31:0] RW_SEED = 32'h9e3779b9;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GATE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OCTAVE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPL     = 3'd5;

	typedef enum logic [1:0] {EV_ON, EV_OFF, EV_TICK, EV_KILL} ev_kind_t;
	typedef enum logic [1:0] {RES_ON, RES_OFF, RES_VERDICT} res_kind_t;
	typedef enum logic [1:0] {PAT_UP, PAT_DOWN, PAT_PINGPONG, PAT_RANDOM} pat_mode_t;
	typedef enum logic [1:0] {DIV_POS, DIV_RAND, DIV_CURSOR, DIV_INDEX} div_sel_t;
	typedef enum logic [1:0] {EMIT_OFF, EMIT_VERDICT, EMIT_ON} emit_sel_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DISPATCH, S_N_REL, S_N_VERD, S_T_OFF_LAST, S_T_DIV, S_T_DEC,
		S_T_REL, S_P_MODE, S_P_START, S_P_DIV1, S_P_START2, S_P_DIV2, S_P_SCAN,
		S_P_EMIT, S_G_CMP, S_G_REL
	} state_t;

	typedef struct packed {
		ev_kind_t                   kind;
		logic signed [PITCH_W-1:0]  note_pitch;
		logic [VEL_W-1:0]           note_velocity;
		logic [POS_W-1:0]           song_position;
	} in_item_t;

	typedef struct packed {
		res_kind_t                  out_kind;
		logic signed [PITCH_W-1:0]  out_pitch;
		logic [VEL_W-1:0]           out_velocity;
		logic                       pass_through;
		logic                       last;
	} out_item_t;

	typedef struct packed {
		logic      kill;
		logic      note_update;
		logic      clear_held;
		logic      clear_known;
		logic      div_start;
		div_sel_t  div_sel;
		logic      step_commit;
		logic      rng_step;
		logic      pick_prep;
		logic      scan_clr;
		logic      scan_step;
		logic      mul_load;
		logic      gate_set;
		logic      emit;
		emit_sel_t emit_sel;
		logic      emit_last;
	} cmd_t;

	typedef struct packed {
		ev_kind_t  kind;
		logic      enable;
		logic      count_zero;
		logic      rel_zero;
		logic      snd_valid;
		logic      len_zero;
		logic      div_busy;
		logic      new_step;
		logic      gate_open;
		logic      gate_hit;
		pat_mode_t mode;
		logic      scan_hit;
		logic      out_free;
	} status_t;

	function automatic logic [OCT_W-1:0] octave_span(input logic [7:0] v);
		logic [2:0] raw;
		if (v <= 8'd42) begin
			raw = 3'd1;
		end else if (v <= 8'd127) begin
			raw = 3'd2;
		end else if (v <= 8'd212) begin
			raw = 3'd3;
		end else begin
			raw = 3'd4;
		end
		if (int'(raw) > MAX_OCTAVES) begin
			return OCT_W'(MAX_OCTAVES);
		end
		return OCT_W'(raw);
	endfunction

endpackage

// File: rtl/core/nar_div.sv
module nar_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [nar_pkg::POS_W-1:0]   dividend,
	input  logic [nar_pkg::LEN_W-1:0]   divisor,
	output logic                        busy,
	output logic [nar_pkg::POS_W-1:0]   quotient,
	output logic [nar_pkg::LEN_W-1:0]   remainder
);

	localparam int CW = $clog2(nar_pkg::POS_W + 1);

	logic [nar_pkg::POS_W-1:0] quo_q;
	logic [nar_pkg::LEN_W-1:0] rem_q;
	logic [nar_pkg::LEN_W-1:0] div_q;
	logic [CW-1:0]             cnt_q;
	logic                      busy_q;
	logic [nar_pkg::LEN_W:0]   sh;
	logic                      fits;

	assign sh   = {rem_q, quo_q[nar_pkg::POS_W-1]};
	assign fits = sh >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(nar_pkg::POS_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[nar_pkg::POS_W-2:0], fits};
			rem_q <= fits ? nar_pkg::LEN_W'(sh - {1'b0, div_q}) : sh[nar_pkg::LEN_W-1:0];
		end
	end

	assign busy      = busy_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// File: rtl/core/nar_datapath.sv
module nar_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  nar_pkg::in_item_t             in_item,
	input  logic                          cfg_write,
	input  logic [nar_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nar_pkg::CFG_W-1:0]     cfg_data,
	input  nar_pkg::cmd_t                 cmd,
	output nar_pkg::status_t              st,
	output logic                          out_valid,
	input  logic                          out_stall,
	output nar_pkg::out_item_t            out_item
);

	localparam int H  = nar_pkg::MAX_HELD;
	localparam int PW = nar_pkg::PITCH_W;
	localparam int TW = nar_pkg::TOT_W;

	logic                          enable_q;
	logic [2:0]                    rate_q;
	nar_pkg::pat_mode_t            mode_q;
	logic [7:0]                    gate_q;
	logic [7:0]                    octv_q;
	logic [nar_pkg::SPL_W-1:0]     spl_q;

	logic signed [PW-1:0]          held_pitch_q [H];
	logic [nar_pkg::VEL_W-1:0]     held_vel_q [H];
	logic [nar_pkg::CNT_W-1:0]     count_q;
	logic signed [PW-1:0]          snd_pitch_q;
	logic                          snd_valid_q;
	logic [nar_pkg::POS_W-1:0]     last_step_q;
	logic                          known_q;
	logic                          gate_done_q;
	logic [TW-1:0]                 cursor_q;
	logic                          down_q;
	logic [31:0]                   rw_q;

	nar_pkg::in_item_t             in_q;
	logic [TW-1:0]                 index_q;
	logic [nar_pkg::IDX_W-1:0]     scan_q;
	logic [nar_pkg::PROD_W-1:0]    prod_a_q;
	logic [nar_pkg::PROD_W-1:0]    prod_b_q;
	logic                          out_valid_q;
	nar_pkg::out_item_t            out_q;

	logic                          div_busy;
	logic [nar_pkg::POS_W-1:0]     div_quo;
	logic [nar_pkg::LEN_W-1:0]     div_rem;
	logic [nar_pkg::POS_W-1:0]     div_a;
	logic [nar_pkg::LEN_W-1:0]     div_b;

	logic [2:0]                    rate_eff;
	logic [nar_pkg::LEN_W-1:0]     half;
	logic [nar_pkg::LEN_W-1:0]     len_raw;
	logic [nar_pkg::LEN_W-1:0]     len;
	logic [nar_pkg::OCT_W-1:0]     oct;
	logic [TW-1:0]                 total;
	logic [H-1:0]                  match;
	logic                          match_any;
	logic [nar_pkg::IDX_W-1:0]     match_idx;
	logic [H-1:0]                  below;
	logic [nar_pkg::CNT_W-1:0]     rank;
	logic signed [nar_pkg::SUM_W-1:0] pitch_sum;
	logic signed [PW-1:0]          pitch_sat;
	logic [TW-1:0]                 cm;
	logic [TW-1:0]                 cm_inc;
	logic [TW-1:0]                 cm_next;
	logic [TW-1:0]                 pp_c;
	logic                          pp_d;
	logic [TW-1:0]                 pp_c2;
	logic [12:0]                   gate_k;
	logic                          out_free;

	assign rate_eff = (rate_q > 3'd5) ? 3'd5 : rate_q;
	assign half     = (nar_pkg::LEN_W'(1) << rate_eff) >> 1;
	assign len_raw  = ((nar_pkg::LEN_W'(spl_q) << 4) + half) >> rate_eff;
	assign len      = (len_raw == '0) ? nar_pkg::LEN_W'(1) : len_raw;
	assign oct      = nar_pkg::octave_span(octv_q);
	assign total    = TW'(count_q) * TW'(oct);
	assign gate_k   = 13'(gate_q) * 13'd19 + 13'd255;

	always_comb begin
		match_idx = '0;
		for (int i = H - 1; i >= 0; i--) begin
			match[i] = (nar_pkg::CNT_W'(i) < count_q) && (held_pitch_q[i] == in_q.note_pitch);
			if (match[i]) begin
				match_idx = nar_pkg::IDX_W'(i);
			end
		end
		for (int j = 0; j < H; j++) begin
			below[j] = (nar_pkg::CNT_W'(j) < count_q) && (held_pitch_q[j] < held_pitch_q[scan_q]);
		end
	end
	assign match_any = |match;
	assign rank      = nar_pkg::CNT_W'($countones(below));

	assign pitch_sum = nar_pkg::SUM_W'(held_pitch_q[scan_q])
		+ $signed(nar_pkg::SUM_W'(div_quo[nar_pkg::OCT_W-1:0]) * nar_pkg::SUM_W'(nar_pkg::OCT_STEP));
	always_comb begin
		if (pitch_sum > nar_pkg::SUM_W'(32767)) begin
			pitch_sat = 16'sh7fff;
		end else if (pitch_sum < -nar_pkg::SUM_W'(32768)) begin
			pitch_sat = -16'sh8000;
		end else begin
			pitch_sat = pitch_sum[PW-1:0];
		end
	end

	assign cm      = div_rem[TW-1:0];
	assign cm_inc  = cm + 1'b1;
	assign cm_next = (cm_inc == total) ? '0 : cm_inc;
	assign pp_c    = (cursor_q > total - 1'b1) ? total - 1'b1 : cursor_q;
	always_comb begin
		if (pp_c == '0) begin
			pp_d = 1'b0;
		end else if (pp_c == total - 1'b1) begin
			pp_d = 1'b1;
		end else begin
			pp_d = down_q;
		end
	end
	assign pp_c2 = pp_d ? pp_c - 1'b1 : pp_c + 1'b1;

	always_comb begin
		case (cmd.div_sel)
			nar_pkg::DIV_POS: begin
				div_a = in_q.song_position;
				div_b = len;
			end
			nar_pkg::DIV_RAND: begin
				div_a = nar_pkg::POS_W'(rw_q);
				div_b = nar_pkg::LEN_W'(total);
			end
			nar_pkg::DIV_CURSOR: begin
				div_a = nar_pkg::POS_W'(cursor_q);
				div_b = nar_pkg::LEN_W'(total);
			end
			default: begin
				div_a = nar_pkg::POS_W'(index_q);
				div_b = nar_pkg::LEN_W'(count_q);
			end
		endcase
	end

	nar_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_a),
		.divisor   (div_b),
		.busy      (div_busy),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			rate_q   <= 3'd4;
			mode_q   <= nar_pkg::PAT_UP;
			gate_q   <= 8'd128;
			octv_q   <= 8'd0;
			spl_q    <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				nar_pkg::REG_ENABLE:  enable_q <= cfg_data[0];
				nar_pkg::REG_RATE:    rate_q   <= cfg_data[2:0];
				nar_pkg::REG_PATTERN: mode_q   <= nar_pkg::pat_mode_t'(cfg_data[1:0]);
				nar_pkg::REG_GATE:    gate_q   <= cfg_data[7:0];
				nar_pkg::REG_OCTAVE:  octv_q   <= cfg_data[7:0];
				nar_pkg::REG_SPL:     spl_q    <= cfg_data[nar_pkg::SPL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			snd_pitch_q <= '0;
			snd_valid_q <= 1'b0;
			last_step_q <= '0;
			known_q     <= 1'b0;
			gate_done_q <= 1'b0;
			cursor_q    <= '0;
			down_q      <= 1'b0;
			rw_q        <= nar_pkg::RW_SEED;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.kill) begin
				count_q     <= '0;
				snd_valid_q <= 1'b0;
				snd_pitch_q <= '0;
				known_q     <= 1'b0;
			end
			if (cmd.clear_held) begin
				count_q <= '0;
			end
			if (cmd.clear_known) begin
				known_q <= 1'b0;
			end
			if (cmd.note_update) begin
				if (in_q.kind == nar_pkg::EV_ON) begin
					if (!match_any && count_q != nar_pkg::CNT_W'(H)) begin
						count_q <= count_q + 1'b1;
						if (count_q == '0) begin
							cursor_q <= '0;
							down_q   <= 1'b0;
							known_q  <= 1'b0;
						end
					end
				end else if (match_any) begin
					count_q <= count_q - 1'b1;
				end
			end
			if (cmd.step_commit) begin
				last_step_q <= div_quo;
				known_q     <= 1'b1;
				gate_done_q <= 1'b0;
			end
			if (cmd.gate_set) begin
				gate_done_q <= 1'b1;
			end
			if (cmd.rng_step) begin
				rw_q <= 32'(rw_q * nar_pkg::LCG_A + nar_pkg::LCG_C);
			end
			if (cmd.pick_prep) begin
				case (mode_q)
					nar_pkg::PAT_UP, nar_pkg::PAT_DOWN: cursor_q <= cm_next;
					nar_pkg::PAT_PINGPONG: begin
						if (total > TW'(1)) begin
							cursor_q <= pp_c2;
							down_q   <= (pp_c2 >= total - 1'b1 || pp_c2 == '0) ? !pp_d : pp_d;
						end else begin
							cursor_q <= pp_c;
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				if (cmd.emit_sel == nar_pkg::EMIT_OFF) begin
					snd_valid_q <= 1'b0;
					snd_pitch_q <= '0;
				end else if (cmd.emit_sel == nar_pkg::EMIT_ON) begin
					snd_valid_q <= 1'b1;
					snd_pitch_q <= pitch_sat;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_q <= in_item;
		end
		if (cmd.note_update) begin
			if (in_q.kind == nar_pkg::EV_ON) begin
				if (!match_any && count_q != nar_pkg::CNT_W'(H)) begin
					held_pitch_q[count_q[nar_pkg::IDX_W-1:0]] <= in_q.note_pitch;
					held_vel_q[count_q[nar_pkg::IDX_W-1:0]]   <= in_q.note_velocity;
				end
			end else if (match_any) begin
				for (int j = 0; j < H - 1; j++) begin
					if (nar_pkg::IDX_W'(j) >= match_idx) begin
						held_pitch_q[j] <= held_pitch_q[j+1];
						held_vel_q[j]   <= held_vel_q[j+1];
					end
				end
			end
		end
		if (cmd.pick_prep) begin
			case (mode_q)
				nar_pkg::PAT_UP:       index_q <= cm;
				nar_pkg::PAT_DOWN:     index_q <= total - 1'b1 - cm;
				nar_pkg::PAT_PINGPONG: index_q <= pp_c;
				default:               index_q <= cm;
			endcase
		end
		if (cmd.scan_clr) begin
			scan_q <= '0;
		end else if (cmd.scan_step) begin
			scan_q <= scan_q + 1'b1;
		end
		if (cmd.mul_load) begin
			prod_a_q <= nar_pkg::PROD_W'(div_rem) * nar_pkg::PROD_W'(5100);
			prod_b_q <= nar_pkg::PROD_W'(len) * nar_pkg::PROD_W'(gate_k);
		end
		if (cmd.emit) begin
			case (cmd.emit_sel)
				nar_pkg::EMIT_ON: begin
					out_q.out_kind     <= nar_pkg::RES_ON;
					out_q.out_pitch    <= pitch_sat;
					out_q.out_velocity <= held_vel_q[scan_q];
					out_q.pass_through <= 1'b0;
				end
				nar_pkg::EMIT_VERDICT: begin
					out_q.out_kind     <= nar_pkg::RES_VERDICT;
					out_q.out_pitch    <= '0;
					out_q.out_velocity <= '0;
					out_q.pass_through <= !enable_q;
				end
				default: begin
					out_q.out_kind     <= nar_pkg::RES_OFF;
					out_q.out_pitch    <= snd_pitch_q;
					out_q.out_velocity <= '0;
					out_q.pass_through <= 1'b0;
				end
			endcase
			out_q.last <= cmd.emit_last;
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		st.kind       = in_q.kind;
		st.enable     = enable_q;
		st.count_zero = (count_q == '0);
		st.rel_zero   = (count_q == '0) || (count_q == nar_pkg::CNT_W'(1) && match_any);
		st.snd_valid  = snd_valid_q;
		st.len_zero   = (spl_q == '0);
		st.div_busy   = div_busy;
		st.new_step   = !known_q || (div_quo != last_step_q);
		st.gate_open  = !gate_done_q && (gate_q != 8'hff);
		st.gate_hit   = prod_a_q >= prod_b_q;
		st.mode       = mode_q;
		st.scan_hit   = (rank == nar_pkg::CNT_W'(div_rem));
		st.out_free   = out_free;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// File: rtl/core/nar_ctrl.sv
module nar_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  nar_pkg::status_t st,
	output nar_pkg::cmd_t    cmd,
	output logic             busy
);

	nar_pkg::state_t state_q;
	nar_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nar_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			nar_pkg::S_IDLE: begin
				busy = 1'b0;
				if (accept) begin
					state_d = nar_pkg::S_DISPATCH;
				end
			end
			nar_pkg::S_DISPATCH: begin
				case (st.kind)
					nar_pkg::EV_KILL: begin
						cmd.kill = 1'b1;
						state_d  = nar_pkg::S_IDLE;
					end
					nar_pkg::EV_TICK: begin
						if (!st.enable || st.count_zero) begin
							cmd.clear_known = 1'b1;
							state_d = st.snd_valid ? nar_pkg::S_T_OFF_LAST : nar_pkg::S_IDLE;
						end else if (st.len_zero) begin
							state_d = nar_pkg::S_IDLE;
						end else begin
							cmd.div_start = 1'b1;
							cmd.div_sel   = nar_pkg::DIV_POS;
							state_d       = nar_pkg::S_T_DIV;
						end
					end
					default: begin
						if (!st.enable) begin
							cmd.clear_held = 1'b1;
							state_d = (!st.count_zero && st.snd_valid) ?
								nar_pkg::S_N_REL : nar_pkg::S_N_VERD;
						end else begin
							cmd.note_update = 1'b1;
							state_d = (st.kind == nar_pkg::EV_OFF && st.snd_valid && st.rel_zero) ?
								nar_pkg::S_N_REL : nar_pkg::S_N_VERD;
						end
					end
				endcase
			end
			nar_pkg::S_N_REL: begin
				if (st.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = nar_pkg::EMIT_OFF;
					state_d      = nar_pkg::S_N_VERD;
				end
			end
			nar_pkg::S_N_VERD: begin
				if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = nar_pkg::EMIT_VERDICT;
					cmd.emit_last = 1'b1;
					state_d       = nar_pkg::S_IDLE;
				end
			end
			nar_pkg::S_T_OFF_LAST, nar_pkg::S_G_REL: begin
				if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = nar_pkg::EMIT_OFF;
					cmd.emit_last = 1'b1;
					state_d       = nar_pkg::S_IDLE;
				end
			end
			nar_pkg::S_T_DIV: begin
				if (!st.div_busy) begin
					state_d = nar_pkg::S_T_DEC;
				end
			end
			nar_pkg::S_T_DEC: begin
				if (st.new_step) begin
					cmd.step_commit = 1'b1;
					state_d = st.snd_valid ? nar_pkg::S_T_REL : nar_pkg::S_P_MODE;
				end else if (st.gate_open) begin
					cmd.mul_load = 1'b1;
					state_d      = nar_pkg::S_G_CMP;
				end else begin
					state_d = nar_pkg::S_IDLE;
				end
			end
			nar_pkg::S_T_REL: begin
				if (st.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = nar_pkg::EMIT_OFF;
					state_d      = nar_pkg::S_P_MODE;
				end
			end
			nar_pkg::S_P_MODE: begin
				case (st.mode)
					nar_pkg::PAT_RANDOM: begin
						cmd.rng_step = 1'b1;
						state_d      = nar_pkg::S_P_START;
					end
					nar_pkg::PAT_PINGPONG: begin
						cmd.pick_prep = 1'b1;
						state_d       = nar_pkg::S_P_START2;
					end
					default: state_d = nar_pkg::S_P_START;
				endcase
			end
			nar_pkg::S_P_START: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = (st.mode == nar_pkg::PAT_RANDOM) ?
					nar_pkg::DIV_RAND : nar_pkg::DIV_CURSOR;
				state_d       = nar_pkg::S_P_DIV1;
			end
			nar_pkg::S_P_DIV1: begin
				if (!st.div_busy) begin
					cmd.pick_prep = 1'b1;
					state_d       = nar_pkg::S_P_START2;
				end
			end
			nar_pkg::S_P_START2: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = nar_pkg::DIV_INDEX;
				cmd.scan_clr  = 1'b1;
				state_d       = nar_pkg::S_P_DIV2;
			end
			nar_pkg::S_P_DIV2: begin
				if (!st.div_busy) begin
					state_d = nar_pkg::S_P_SCAN;
				end
			end
			nar_pkg::S_P_SCAN: begin
				if (st.scan_hit) begin
					state_d = nar_pkg::S_P_EMIT;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			nar_pkg::S_P_EMIT: begin
				if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = nar_pkg::EMIT_ON;
					cmd.emit_last = 1'b1;
					state_d       = nar_pkg::S_IDLE;
				end
			end
			nar_pkg::S_G_CMP: begin
				if (st.gate_hit) begin
					cmd.gate_set = 1'b1;
					state_d = st.snd_valid ? nar_pkg::S_G_REL : nar_pkg::S_IDLE;
				end else begin
					state_d = nar_pkg::S_IDLE;
				end
			end
			default: state_d = nar_pkg::S_IDLE;
		endcase
	end

endmodule

// File: rtl/core/note_arpeggiator.sv
// Channel   Handshake                   Payload
// event     event_valid / event_stall   event_data  (nar_pkg::in_item_t)
// result    result_valid / result_stall result_data (nar_pkg::out_item_t)
// cfg       cfg_write                   cfg_index, cfg_data
//
// One item is worked on at a time. Kills, note events and ticks with nothing to play
// finish without the divider. Other ticks divide the position on the shared 48-step
// divider; a new step divides once more for ping-pong, twice otherwise, and scans the
// held notes. Reset clears all control state at once.
// A stalled result waits in the output register; the block stops only at a further result.
module note_arpeggiator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          event_valid,
	output logic                          event_stall,
	input  nar_pkg::in_item_t             event_data,
	output logic                          result_valid,
	input  logic                          result_stall,
	output nar_pkg::out_item_t            result_data,
	input  logic                          cfg_write,
	input  logic [nar_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nar_pkg::CFG_W-1:0]     cfg_data
);

	nar_pkg::cmd_t    cmd;
	nar_pkg::status_t st;
	logic             busy;
	logic             accept;

	assign event_stall = busy;
	assign accept      = event_valid && !busy;

	nar_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy)
	);

	nar_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_item   (event_data),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.st        (st),
		.out_valid (result_valid),
		.out_stall (result_stall),
		.out_item  (result_data)
	);

endmodule

// File: rtl/core/nar_checker.sv
module nar_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               event_valid,
	input logic               event_stall,
	input logic               result_valid,
	input logic               result_stall,
	input nar_pkg::out_item_t result_data
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_data))
		else $error("stalled result changed");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && !event_stall |=> event_stall)
		else $error("block took a second item at once");

	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.out_kind == nar_pkg::RES_VERDICT |->
		result_data.last && result_data.out_pitch == '0 && result_data.out_velocity == '0)
		else $error("malformed verdict");

	a_off: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.out_kind != nar_pkg::RES_VERDICT |->
		!result_data.pass_through)
		else $error("pass flag outside a verdict");

endmodule

bind note_arpeggiator nar_checker u_nar_checker (.*);
